### src/sorted_ring_membership_list_macros.svh
// ----------------------------------------------------------------------------
// sorted ring membership list assertion macros
// shared concurrent assertion forms used by the top level
// ----------------------------------------------------------------------------
`ifndef SORTED_RING_MEMBERSHIP_LIST_MACROS_SVH
`define SORTED_RING_MEMBERSHIP_LIST_MACROS_SVH

// same-cycle implication
`define SRML_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SRML_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/srml_pkg.sv
// ----------------------------------------------------------------------------
// srml_pkg
// sizes, codes and shared types of the sorted ring membership list
// ----------------------------------------------------------------------------
package srml_pkg;

    localparam int CAPACITY = 16;
    localparam int ID_BITS  = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic [ID_BITS-1:0] id_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [15:0]        id_port_t;
    typedef logic [4:0]         cnt_port_t;

    // codes 2 and 3 look up
    typedef logic [1:0] func_t;
    localparam func_t FN_INSERT = 2'd0;
    localparam func_t FN_REMOVE = 2'd1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2,
        ST_DUP    = 2'd3
    } status_t;

    typedef struct packed {
        logic    valid;
        status_t status;
        logic    nbr_valid;
        id_t     pred;
        id_t     succ;
        cnt_t    count;
    } result_t;

endpackage

### src/sorted_ring_membership_list.sv
// ----------------------------------------------------------------------------
// sorted_ring_membership_list
// Keeps up to 16 member ids in ascending order as a ring and answers insert,
// remove and look up requests with a status, the circular predecessor and
// successor and the member count. One request at a time: a word is taken
// when the sequencer is idle. A scan reads one list entry per cycle
// through the ram read port while the same pass shifts entries through
// the write port; an empty list or an insert into a full list skips the
// scan. The sequencer is ready again in the cycle after the output
// register loads. A finished word waits in the output register, and the
// next request may be taken meanwhile. No clearing pass is needed after
// reset.
// ----------------------------------------------------------------------------
`include "sorted_ring_membership_list_macros.svh"

module sorted_ring_membership_list (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [15:0] s_member_id,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_neighbours_valid,
    output logic [15:0] m_pred_id,
    output logic [15:0] m_succ_id,
    output logic [4:0]  m_member_count
);

    srml_pkg::result_t res;
    logic              seq_idle;
    logic              start;
    logic              grant;
    logic              ram_we;
    srml_pkg::idx_t    ram_waddr;
    srml_pkg::id_t     ram_wdata;
    srml_pkg::idx_t    ram_raddr;
    srml_pkg::id_t     ram_rdata;

    logic              m_valid_reg, m_valid_next;
    logic [1:0]        status_reg;
    logic              nv_reg;
    logic [15:0]       pred_reg;
    logic [15:0]       succ_reg;
    logic [4:0]        count_reg;

    logic              s_fire;
    logic              s_hold;
    logic              m_nbr_off;
    logic              nbr_ids_zero;
    logic              count_in_range;

    assign s_ready = seq_idle;
    assign start   = s_valid && seq_idle;
    assign grant   = !m_valid_reg || m_ready;

    srml_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .in_func   (s_func),
        .in_id     (s_member_id[srml_pkg::ID_BITS-1:0]),
        .idle      (seq_idle),
        .grant     (grant),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    srml_ram #(
        .DEPTH (srml_pkg::CAPACITY),
        .WIDTH (srml_pkg::ID_BITS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res.valid && grant) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (res.valid && grant) begin
            status_reg <= res.status;
            nv_reg     <= res.nbr_valid;
            pred_reg   <= srml_pkg::id_port_t'(res.pred);
            succ_reg   <= srml_pkg::id_port_t'(res.succ);
            count_reg  <= srml_pkg::cnt_port_t'(res.count);
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = status_reg;
    assign m_neighbours_valid = nv_reg;
    assign m_pred_id          = pred_reg;
    assign m_succ_id          = succ_reg;
    assign m_member_count     = count_reg;

    assign s_fire         = s_valid && s_ready;
    assign s_hold         = s_ready && !s_valid;
    assign m_nbr_off      = m_valid && !m_neighbours_valid;
    assign nbr_ids_zero   = (m_pred_id == 16'd0) && (m_succ_id == 16'd0);
    assign count_in_range = (res.count <= srml_pkg::cnt_t'(srml_pkg::CAPACITY));

    `SRML_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_fire, !s_ready, "ready after accept")
    `SRML_ASSERT_NOW(a_zero_nbrs, aclk, aresetn, m_nbr_off, nbr_ids_zero, "neighbours not zero")
    `SRML_ASSERT_NEXT(a_count_idle, aclk, aresetn, s_hold, $stable(res.count), "idle count moved")
    `SRML_ASSERT_NOW(a_count_cap, aclk, aresetn, 1'b1, count_in_range, "count above capacity")

endmodule

### src/srml_ram.sv
// ----------------------------------------------------------------------------
// srml_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module srml_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/srml_seq.sv
// ----------------------------------------------------------------------------
// srml_seq
// scan sequencer: one pass over the list finds the id, its neighbours and
// shifts entries on insert or remove through the single ram port pair
// ----------------------------------------------------------------------------
module srml_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  srml_pkg::func_t       in_func,
    input  srml_pkg::id_t         in_id,
    output logic                  idle,
    input  logic                  grant,
    output srml_pkg::result_t     res,
    output logic                  ram_we,
    output srml_pkg::idx_t        ram_waddr,
    output srml_pkg::id_t         ram_wdata,
    output srml_pkg::idx_t        ram_raddr,
    input  srml_pkg::id_t         ram_rdata
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_FINISH = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    srml_pkg::func_t   func_reg, func_next;
    srml_pkg::id_t     id_reg, id_next;
    srml_pkg::cnt_t    count_reg, count_next;
    srml_pkg::cnt_t    idx_reg, idx_next;
    srml_pkg::idx_t    pidx_reg, pidx_next;
    logic              rvld_reg, rvld_next;
    srml_pkg::id_t     prev_reg, prev_next;
    srml_pkg::id_t     first_reg, first_next;
    srml_pkg::id_t     carry_reg, carry_next;
    srml_pkg::id_t     pred_reg, pred_next;
    srml_pkg::id_t     succ_reg, succ_next;
    logic              hit_reg, hit_next;
    logic              dup_reg, dup_next;
    logic              need_succ_reg, need_succ_next;
    logic              pred_last_reg, pred_last_next;
    logic              succ_first_reg, succ_first_next;
    srml_pkg::status_t status_reg, status_next;
    logic              nv_reg, nv_next;

    logic              is_ins;
    logic              is_rem;
    logic              is_last;
    srml_pkg::id_t     d;

    assign is_ins  = (func_reg == srml_pkg::FN_INSERT);
    assign is_rem  = (func_reg == srml_pkg::FN_REMOVE);
    assign d       = ram_rdata;
    assign is_last = (srml_pkg::cnt_t'(pidx_reg) == count_reg - srml_pkg::cnt_t'(1));

    always_comb begin
        state_next      = state_reg;
        func_next       = func_reg;
        id_next         = id_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pidx_next       = pidx_reg;
        rvld_next       = rvld_reg;
        prev_next       = prev_reg;
        first_next      = first_reg;
        carry_next      = carry_reg;
        pred_next       = pred_reg;
        succ_next       = succ_reg;
        hit_next        = hit_reg;
        dup_next        = dup_reg;
        need_succ_next  = need_succ_reg;
        pred_last_next  = pred_last_reg;
        succ_first_next = succ_first_reg;
        status_next     = status_reg;
        nv_next         = nv_reg;
        ram_we          = 1'b0;
        ram_waddr       = pidx_reg;
        ram_wdata       = d;
        ram_raddr       = idx_reg[srml_pkg::IDX_W-1:0];

        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    func_next       = in_func;
                    id_next         = in_id;
                    idx_next        = '0;
                    rvld_next       = 1'b0;
                    hit_next        = 1'b0;
                    dup_next        = 1'b0;
                    need_succ_next  = 1'b0;
                    pred_last_next  = 1'b0;
                    succ_first_next = 1'b0;
                    if (in_func == srml_pkg::FN_INSERT &&
                        count_reg == srml_pkg::cnt_t'(srml_pkg::CAPACITY)) begin
                        status_next = srml_pkg::ST_FULL;
                        nv_next     = 1'b0;
                        state_next  = S_DONE;
                    end else if (count_reg == '0) begin
                        state_next = S_FINISH;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // read issue, data back in the next cycle
                if (idx_reg < count_reg) begin
                    rvld_next = 1'b1;
                    pidx_next = idx_reg[srml_pkg::IDX_W-1:0];
                    idx_next  = idx_reg + srml_pkg::cnt_t'(1);
                end else begin
                    rvld_next = 1'b0;
                end
                if (rvld_reg) begin
                    prev_next = d;
                    if (pidx_reg == '0) begin
                        first_next = d;
                    end
                    if (is_ins) begin
                        if (!hit_reg && !dup_reg) begin
                            if (d == id_reg) begin
                                dup_next = 1'b1;
                            end else if (d > id_reg) begin
                                // insert point, shift the rest up
                                hit_next       = 1'b1;
                                ram_we         = 1'b1;
                                ram_wdata      = id_reg;
                                carry_next     = d;
                                pred_next      = prev_reg;
                                pred_last_next = (pidx_reg == '0);
                                succ_next      = d;
                            end
                        end else if (hit_reg) begin
                            ram_we     = 1'b1;
                            ram_wdata  = carry_reg;
                            carry_next = d;
                        end
                    end else begin
                        if (!hit_reg) begin
                            if (d == id_reg) begin
                                hit_next        = 1'b1;
                                pred_next       = prev_reg;
                                pred_last_next  = (pidx_reg == '0);
                                succ_first_next = is_last;
                                need_succ_next  = !is_last;
                            end
                        end else begin
                            if (need_succ_reg) begin
                                succ_next      = d;
                                need_succ_next = 1'b0;
                            end
                            if (is_rem) begin
                                // shift down over the removed entry
                                ram_we    = 1'b1;
                                ram_waddr = pidx_reg - srml_pkg::idx_t'(1);
                                ram_wdata = d;
                            end
                        end
                    end
                    if (is_last) begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (is_ins) begin
                    if (dup_reg) begin
                        status_next = srml_pkg::ST_DUP;
                        nv_next     = 1'b0;
                    end else begin
                        ram_we      = 1'b1;
                        ram_waddr   = count_reg[srml_pkg::IDX_W-1:0];
                        ram_wdata   = hit_reg ? carry_reg : id_reg;
                        count_next  = count_reg + srml_pkg::cnt_t'(1);
                        status_next = srml_pkg::ST_OK;
                        nv_next     = 1'b1;
                        if (!hit_reg) begin
                            // appended at the tail
                            pred_next = (count_reg == '0) ? id_reg : prev_reg;
                            succ_next = (count_reg == '0) ? id_reg : first_reg;
                        end else if (pred_last_reg) begin
                            pred_next = prev_reg;
                        end
                    end
                end else if (!hit_reg) begin
                    status_next = srml_pkg::ST_ABSENT;
                    nv_next     = 1'b0;
                end else begin
                    status_next = srml_pkg::ST_OK;
                    nv_next     = 1'b1;
                    if (pred_last_reg) begin
                        pred_next = prev_reg;
                    end
                    if (succ_first_reg) begin
                        succ_next = first_reg;
                    end
                    if (is_rem) begin
                        count_next = count_reg - srml_pkg::cnt_t'(1);
                    end
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (grant) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rvld_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            rvld_reg  <= rvld_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg       <= func_next;
        id_reg         <= id_next;
        idx_reg        <= idx_next;
        pidx_reg       <= pidx_next;
        prev_reg       <= prev_next;
        first_reg      <= first_next;
        carry_reg      <= carry_next;
        pred_reg       <= pred_next;
        succ_reg       <= succ_next;
        hit_reg        <= hit_next;
        dup_reg        <= dup_next;
        need_succ_reg  <= need_succ_next;
        pred_last_reg  <= pred_last_next;
        succ_first_reg <= succ_first_next;
        status_reg     <= status_next;
        nv_reg         <= nv_next;
    end

    assign idle          = (state_reg == S_IDLE);
    assign res.valid     = (state_reg == S_DONE);
    assign res.status    = status_reg;
    assign res.nbr_valid = nv_reg;
    assign res.pred      = nv_reg ? pred_reg : '0;
    assign res.succ      = nv_reg ? succ_reg : '0;
    assign res.count     = count_reg;

endmodule
